// ----- src/vln_pkg.sv -----
// Shared types for the vector length / normalize block.
// No dependencies.
package vln_pkg;

    localparam int NUM_AXES = 3;

    // Control tag carried alongside each beat through the cell chains.
    typedef struct packed {
        logic                vld;
        logic                zero;
        logic [NUM_AXES-1:0] neg;
    } t_tag;

endpackage

// ----- src/vln_if.sv -----
// Stream interfaces for the vector length / normalize block.
// Depends on nothing; widths come from interface parameters.
interface vln_in_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] comp_x;
    logic signed [CW-1:0] comp_y;
    logic signed [CW-1:0] comp_z;
    modport source(output valid, comp_x, comp_y, comp_z, input ready);
    modport sink(input valid, comp_x, comp_y, comp_z, output ready);
    modport monitor(input valid, ready, comp_x, comp_y, comp_z);
endinterface

interface vln_out_if #(parameter int CW = 16, parameter int UW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [UW-1:0] unit_x;
    logic signed [UW-1:0] unit_y;
    logic signed [UW-1:0] unit_z;
    logic        [CW-1:0] vec_length;
    logic                 is_zero;
    modport source(output valid, unit_x, unit_y, unit_z, vec_length, is_zero,
                   input ready);
    modport sink(input valid, unit_x, unit_y, unit_z, vec_length, is_zero,
                 output ready);
    modport monitor(input valid, ready, unit_x, unit_y, unit_z, vec_length,
                    is_zero);
endinterface

// ----- src/vln_sqrt_cell.sv -----
// One result bit of the digit-by-digit integer square root.
// Depends on vln_pkg (t_tag).
module vln_sqrt_cell #(
    parameter int CW = 16,
    parameter int PW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vln_pkg::t_tag     i_tag,
    input  logic [2*CW-1:0]   i_n,
    input  logic [CW+1:0]     i_rem,
    input  logic [CW-1:0]     i_root,
    input  logic [PW-1:0]     i_pass,
    output vln_pkg::t_tag     o_tag,
    output logic [2*CW-1:0]   o_n,
    output logic [CW+1:0]     o_rem,
    output logic [CW-1:0]     o_root,
    output logic [PW-1:0]     o_pass
);
    logic [CW+1:0] rem2;
    logic [CW+1:0] trial;
    logic          ge;
    vln_pkg::t_tag r_tag;
    logic [2*CW-1:0] r_n;
    logic [CW+1:0] r_rem;
    logic [CW-1:0] r_root;
    logic [PW-1:0] r_pass;

    always_comb begin
        rem2  = {i_rem[CW-1:0], i_n[2*CW-1 -: 2]};
        trial = {i_root, 2'b01};
        ge    = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= {i_n[2*CW-3:0], 2'b00};
            r_rem  <= ge ? (rem2 - trial) : rem2;
            r_root <= {i_root[CW-2:0], ge};
            r_pass <= i_pass;
        end
    end

    assign o_tag  = r_tag;
    assign o_n    = r_n;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pass = r_pass;
endmodule

// ----- src/vln_div_cell.sv -----
// One quotient bit of the three restoring dividers (one lane per axis).
// Depends on vln_pkg (t_tag, NUM_AXES).
module vln_div_cell #(
    parameter int CW = 16,
    parameter int QW = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  vln_pkg::t_tag                       i_tag,
    input  logic [CW-1:0]                       i_len,
    input  logic [vln_pkg::NUM_AXES-1:0][CW:0]  i_rem,
    input  logic [vln_pkg::NUM_AXES-1:0][QW-1:0] i_q,
    output vln_pkg::t_tag                       o_tag,
    output logic [CW-1:0]                       o_len,
    output logic [vln_pkg::NUM_AXES-1:0][CW:0]  o_rem,
    output logic [vln_pkg::NUM_AXES-1:0][QW-1:0] o_q
);
    vln_pkg::t_tag                        r_tag;
    logic [CW-1:0]                        r_len;
    logic [vln_pkg::NUM_AXES-1:0][CW:0]   r_rem;
    logic [vln_pkg::NUM_AXES-1:0][QW-1:0] r_q;
    logic [vln_pkg::NUM_AXES-1:0][CW:0]   n_rem;
    logic [vln_pkg::NUM_AXES-1:0][QW-1:0] n_q;
    logic [CW:0]                          len_x;

    always_comb begin
        logic       ge;
        logic [CW:0] diff;
        len_x = {1'b0, i_len};
        for (int a = 0; a < vln_pkg::NUM_AXES; a++) begin
            ge       = (i_rem[a] >= len_x);
            diff     = ge ? (i_rem[a] - len_x) : i_rem[a];
            // remainder stays below the length, so the shift cannot overflow
            n_rem[a] = {diff[CW-1:0], 1'b0};
            n_q[a]   = {i_q[a][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= i_len;
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_tag = r_tag;
    assign o_len = r_len;
    assign o_rem = r_rem;
    assign o_q   = r_q;
endmodule

// ----- src/vector3_length_normalize.sv -----
// Vector length and normalize: top level, input stages, cell chains, output register.
// Depends on vln_pkg, vln_if, vln_sqrt_cell, vln_div_cell.
//
// Usage:
//   i_vec carries one 3D vector per beat (comp_x/y/z, signed COMP_WIDTH bits).
//   o_vec carries one result per beat: unit_x/y/z in signed Q2.FRAC_BITS,
//   truncated toward zero, vec_length = floor(sqrt(x^2+y^2+z^2)), is_zero.
//   A zero vector returns all zeros with is_zero set.
//   Throughput: one beat per cycle while the receiver does not stall.
//   Pipeline: registered magnitude, squares and sum stages, COMP_WIDTH
//   square root cells (one root bit each), FRAC_BITS+1 divider cells
//   (one quotient bit each, three axes side by side), one output register.
//   Backpressure: the whole pipe advances when the output register is empty
//   or being taken; when the receiver stalls, everything holds and
//   i_vec.ready drops. No beats are lost or duplicated.
//   Reset clears all valid flags; the pipe is empty after reset.
module vector3_length_normalize #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input logic      i_clk,
    input logic      i_rst_n,
    vln_in_if.sink   i_vec,
    vln_out_if.source o_vec
);
    localparam int CW = COMP_WIDTH;
    localparam int QW = FRAC_BITS + 1;
    localparam int UW = FRAC_BITS + 2;
    localparam int NA = vln_pkg::NUM_AXES;
    localparam int PW = NA * CW;

    logic en;

    // stage 1: magnitudes
    vln_pkg::t_tag          r_tag1;
    logic [NA-1:0][CW-1:0]  r_mag1;
    logic [NA-1:0][CW-1:0]  n_mag1;
    logic [NA-1:0][CW-1:0]  raw;
    // stage 2: squares
    vln_pkg::t_tag           r_tag2;
    logic [NA-1:0][CW-1:0]   r_mag2;
    logic [NA-1:0][2*CW-1:0] r_sq2;
    // stage 3: sum
    vln_pkg::t_tag          r_tag3;
    logic [NA-1:0][CW-1:0]  r_mag3;
    logic [2*CW-1:0]        r_sum3;

    assign en          = !o_vec.valid || o_vec.ready;
    assign i_vec.ready = en;

    always_comb begin
        raw[0] = i_vec.comp_x;
        raw[1] = i_vec.comp_y;
        raw[2] = i_vec.comp_z;
        for (int a = 0; a < NA; a++) begin
            n_mag1[a] = raw[a][CW-1] ? (~raw[a] + 1'b1) : raw[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.vld <= 1'b0;
            r_tag2.vld <= 1'b0;
            r_tag3.vld <= 1'b0;
        end else if (en) begin
            r_tag1.vld <= i_vec.valid;
            r_tag2.vld <= r_tag1.vld;
            r_tag3.vld <= r_tag2.vld;
        end
        if (en) begin
            r_tag1.zero <= (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
            for (int a = 0; a < NA; a++) begin
                r_tag1.neg[a] <= raw[a][CW-1];
            end
            r_mag1 <= n_mag1;
            r_tag2.zero <= r_tag1.zero;
            r_tag2.neg  <= r_tag1.neg;
            r_mag2      <= r_mag1;
            for (int a = 0; a < NA; a++) begin
                r_sq2[a] <= r_mag1[a] * r_mag1[a];
            end
            r_tag3.zero <= r_tag2.zero;
            r_tag3.neg  <= r_tag2.neg;
            r_mag3      <= r_mag2;
            // sum of three squares of magnitudes <= 2^(CW-1) fits 2*CW bits
            r_sum3 <= r_sq2[0] + r_sq2[1] + r_sq2[2];
        end
    end

    // square root chain
    vln_pkg::t_tag   s_tag  [CW+1];
    logic [2*CW-1:0] s_n    [CW+1];
    logic [CW+1:0]   s_rem  [CW+1];
    logic [CW-1:0]   s_root [CW+1];
    logic [PW-1:0]   s_pass [CW+1];

    assign s_tag[0]  = r_tag3;
    assign s_n[0]    = r_sum3;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_pass[0] = r_mag3;

    for (genvar k = 0; k < CW; k++) begin : g_sqrt
        vln_sqrt_cell #(.CW(CW), .PW(PW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_tag  (s_tag[k]),
            .i_n    (s_n[k]),
            .i_rem  (s_rem[k]),
            .i_root (s_root[k]),
            .i_pass (s_pass[k]),
            .o_tag  (s_tag[k+1]),
            .o_n    (s_n[k+1]),
            .o_rem  (s_rem[k+1]),
            .o_root (s_root[k+1]),
            .o_pass (s_pass[k+1])
        );
    end

    // divider chain
    vln_pkg::t_tag         d_tag [QW+1];
    logic [CW-1:0]         d_len [QW+1];
    logic [NA-1:0][CW:0]   d_rem [QW+1];
    logic [NA-1:0][QW-1:0] d_q   [QW+1];
    logic [NA-1:0][CW-1:0] mag_s;

    assign mag_s    = s_pass[CW];
    assign d_tag[0] = s_tag[CW];
    assign d_len[0] = s_root[CW];
    assign d_q[0]   = '0;
    for (genvar a = 0; a < NA; a++) begin : g_rem0
        assign d_rem[0][a] = {1'b0, mag_s[a]};
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        vln_div_cell #(.CW(CW), .QW(QW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_tag  (d_tag[k]),
            .i_len  (d_len[k]),
            .i_rem  (d_rem[k]),
            .i_q    (d_q[k]),
            .o_tag  (d_tag[k+1]),
            .o_len  (d_len[k+1]),
            .o_rem  (d_rem[k+1]),
            .o_q    (d_q[k+1])
        );
    end

    // output register
    logic                  r_out_vld;
    logic [NA-1:0][UW-1:0] r_unit;
    logic [NA-1:0][UW-1:0] n_unit;
    logic [CW-1:0]         r_len;
    logic                  r_zero;
    vln_pkg::t_tag         f_tag;

    assign f_tag = d_tag[QW];

    always_comb begin
        logic [UW-1:0] qx;
        for (int a = 0; a < NA; a++) begin
            qx = {1'b0, d_q[QW][a]};
            if (f_tag.zero) begin
                n_unit[a] = '0;
            end else begin
                n_unit[a] = f_tag.neg[a] ? (~qx + 1'b1) : qx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= f_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_unit <= n_unit;
            r_len  <= f_tag.zero ? '0 : d_len[QW];
            r_zero <= f_tag.zero;
        end
    end

    assign o_vec.valid      = r_out_vld;
    assign o_vec.unit_x     = r_unit[0];
    assign o_vec.unit_y     = r_unit[1];
    assign o_vec.unit_z     = r_unit[2];
    assign o_vec.vec_length = r_len;
    assign o_vec.is_zero    = r_zero;
endmodule
